FILE: rtl/vn2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_pkg
// Shared constants, types and the cosine weight table for the 2D value
// noise sampler.
// ----------------------------------------------------------------------------
package vn2d_pkg;

    localparam int ROW_STEP        = 57;
    localparam int COORD_FRAC_BITS = 16;
    localparam int COS_TABLE_DEPTH = 1024;

    localparam int HALF_STEPS = 2 * COS_TABLE_DEPTH;
    localparam int KW         = $clog2(HALF_STEPS + 1);
    localparam int AW         = $clog2(COS_TABLE_DEPTH + 1);
    localparam int POSW       = 32 + COORD_FRAC_BITS;
    localparam int WW         = 17;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    localparam logic [31:0] HASH_MUL  = 32'd60493;
    localparam logic [31:0] HASH_ADD1 = 32'd19990303;
    localparam logic [31:0] HASH_ADD2 = 32'd3521384707;

    typedef logic [WW-1:0] t_wtab [0:COS_TABLE_DEPTH];

    // Restoring long division, used only while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter-period table: (1 - cos(pi*j/H)) / 2 in Q0.16, Taylor series in Q30
    function automatic t_wtab build_wtab();
        t_wtab       t;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] dv;
        logic        sub;
        for (int j = 0; j <= COS_TABLE_DEPTH; j++) begin
            th   = udiv64(PI_Q30 * 64'(j), 64'(HALF_STEPS));
            th2  = (th * th) >> 30;
            term = th2 >> 1;
            sum  = term;
            sub  = 1'b1;
            for (int n = 2; n < 40; n++) begin
                if (term != 64'd0) begin
                    dv   = 64'((2 * n - 1) * (2 * n));
                    term = udiv64((term * th2) >> 30, dv);
                    if (sub) begin
                        sum = (sum >= term) ? sum - term : 64'd0;
                    end else begin
                        sum = sum + term;
                    end
                    sub = !sub;
                end
            end
            if (sum > ONE_Q30) begin
                sum = ONE_Q30;
            end
            t[j] = WW'((sum + 64'd16384) >> 15);
        end
        return t;
    endfunction

endpackage

FILE: rtl/vn2d_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_in_if / vn2d_out_if
// Valid/ready channels for sample items and noise results.
// ----------------------------------------------------------------------------
interface vn2d_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] coord_x;
    logic [47:0] coord_z;
    logic [47:0] offset_x;
    logic [47:0] offset_z;
    logic [23:0] frequency;
    logic        slot_valid;
    logic        last_octave;

    modport source (output valid, coord_x, coord_z, offset_x, offset_z, frequency,
                    slot_valid, last_octave, input ready);
    modport sink   (input valid, coord_x, coord_z, offset_x, offset_z, frequency,
                    slot_valid, last_octave, output ready);
endinterface

interface vn2d_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] noise_value;
    logic        last_out;

    modport source (output valid, noise_value, last_out, input ready);
    modport sink   (input valid, noise_value, last_out, output ready);
endinterface

FILE: rtl/value_noise_2d_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_sampler
// One octave of 2D value noise with cosine-weighted bilinear blending.
//
//   channel | dir | payload
//   i_in    | in  | coord_x, coord_z, offset_x, offset_z, frequency,
//           |     | slot_valid, last_octave
//   o_out   | out | noise_value, last_out
//
// Nine register stages, one item per cycle while o_out does not stall: two for the
// scaled positions, one for the row base and table addresses, four for the
// lattice hash, two for the blends along x and z.
// Reset clears only the stage valid bits.
// A stall on o_out freezes every stage; ready is high whenever the output
// register is empty or being taken.
// ----------------------------------------------------------------------------
module value_noise_2d_sampler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vn2d_in_if.sink         i_in,
    vn2d_out_if.source      o_out
);
    import vn2d_pkg::*;

    localparam int NST = 9;

    logic               en;
    logic               r_vld  [1:NST];
    logic               r_last [1:NST];
    logic               r_slot [1:NST];

    logic [POSW-1:0]    pos_x;
    logic [POSW-1:0]    pos_z;

    logic [31:0]        r3_ix;
    logic [31:0]        r3_r0;
    logic [AW-1:0]      r3_ax;
    logic [AW-1:0]      r3_az;
    logic               r3_mx;
    logic               r3_mz;
    logic               r4_mx;
    logic               r4_mz;
    logic [WW-1:0]      t_x;
    logic [WW-1:0]      t_z;
    logic [WW-1:0]      r5_wx;
    logic [WW-1:0]      r5_wz;
    logic [WW-1:0]      r6_wx;
    logic [WW-1:0]      r6_wz;
    logic [WW-1:0]      r7_wx;
    logic [WW-1:0]      r7_wz;
    logic [WW-1:0]      r8_wz;

    logic [31:0]        idx_a;
    logic [31:0]        idx_b;
    logic [31:0]        idx_c;
    logic [31:0]        idx_d;
    logic signed [31:0] cn_a;
    logic signed [31:0] cn_b;
    logic signed [31:0] cn_c;
    logic signed [31:0] cn_d;

    logic signed [31:0] r8_lo;
    logic signed [31:0] r8_hi;
    logic signed [31:0] n_lo;
    logic signed [31:0] n_hi;
    logic signed [31:0] r9_res;
    logic signed [31:0] n_res;

    logic [KW-1:0]      kx;
    logic [KW-1:0]      kz;
    logic [AW-1:0]      ax;
    logic [AW-1:0]      az;
    logic               mx;
    logic               mz;

    assign en         = !r_vld[NST] || o_out.ready;
    assign i_in.ready = en;

    // Control travels alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= i_in.valid;
            for (int s = 2; s <= NST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last[1] <= i_in.last_octave;
            r_slot[1] <= i_in.slot_valid;
            for (int s = 2; s <= NST; s++) begin
                r_last[s] <= r_last[s-1];
                r_slot[s] <= r_slot[s-1];
            end
        end
    end

    // Stages 1-2: scaled positions
    vn2d_pos u_pos_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_coord  (i_in.coord_x),
        .i_offset (i_in.offset_x),
        .i_freq   (i_in.frequency),
        .o_pos    (pos_x)
    );

    vn2d_pos u_pos_z (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_coord  (i_in.coord_z),
        .i_offset (i_in.offset_z),
        .i_freq   (i_in.frequency),
        .o_pos    (pos_z)
    );

    // Stage 3: row base and table addresses; upper half mirrors the table
    always_comb begin
        kx = KW'((POSW'(pos_x[COORD_FRAC_BITS-1:0]) * POSW'(HALF_STEPS)) >> COORD_FRAC_BITS);
        kz = KW'((POSW'(pos_z[COORD_FRAC_BITS-1:0]) * POSW'(HALF_STEPS)) >> COORD_FRAC_BITS);
        mx = (kx > KW'(COS_TABLE_DEPTH));
        mz = (kz > KW'(COS_TABLE_DEPTH));
        ax = mx ? AW'(KW'(HALF_STEPS) - kx) : AW'(kx);
        az = mz ? AW'(KW'(HALF_STEPS) - kz) : AW'(kz);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ix <= pos_x[COORD_FRAC_BITS +: 32];
            r3_r0 <= pos_z[COORD_FRAC_BITS +: 32] * 32'(ROW_STEP);
            r3_ax <= ax;
            r3_az <= az;
            r3_mx <= mx;
            r3_mz <= mz;
        end
    end

    // Stage 4: table read, corner indices into the hash pipes
    vn2d_wrom u_wrom_x (.i_clk(i_clk), .i_en(en), .i_addr(r3_ax), .o_data(t_x));
    vn2d_wrom u_wrom_z (.i_clk(i_clk), .i_en(en), .i_addr(r3_az), .o_data(t_z));

    assign idx_a = r3_ix + r3_r0;
    assign idx_b = idx_a + 32'd1;
    assign idx_c = idx_a + 32'(ROW_STEP);
    assign idx_d = idx_c + 32'd1;

    vn2d_hash u_hash_a (.i_clk(i_clk), .i_en(en), .i_idx(idx_a), .o_corner(cn_a));
    vn2d_hash u_hash_b (.i_clk(i_clk), .i_en(en), .i_idx(idx_b), .o_corner(cn_b));
    vn2d_hash u_hash_c (.i_clk(i_clk), .i_en(en), .i_idx(idx_c), .o_corner(cn_c));
    vn2d_hash u_hash_d (.i_clk(i_clk), .i_en(en), .i_idx(idx_d), .o_corner(cn_d));

    // Stages 5-7: hold weights until the corners are ready
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mx <= r3_mx;
            r4_mz <= r3_mz;
            r5_wx <= r4_mx ? WW'(17'd65536 - t_x) : t_x;
            r5_wz <= r4_mz ? WW'(17'd65536 - t_z) : t_z;
            r6_wx <= r5_wx;
            r6_wz <= r5_wz;
            r7_wx <= r6_wx;
            r7_wz <= r6_wz;
            r8_wz <= r7_wz;
        end
    end

    // Stages 8-9: blend along x, then along z (floor by arithmetic shift)
    function automatic logic signed [31:0] blend(input logic signed [31:0] p,
                                                 input logic signed [31:0] q,
                                                 input logic [WW-1:0] t);
        logic signed [32:0] df;
        logic signed [50:0] pr;
        df = 33'(q) - 33'(p);
        pr = 51'(df) * $signed({1'b0, t});
        return 32'(51'(p) + (pr >>> 16));
    endfunction

    assign n_lo  = blend(cn_a, cn_b, r7_wx);
    assign n_hi  = blend(cn_c, cn_d, r7_wx);
    assign n_res = r_slot[8] ? blend(r8_lo, r8_hi, r8_wz) : 32'sd0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_lo  <= n_lo;
            r8_hi  <= n_hi;
            r9_res <= n_res;
        end
    end

    assign o_out.valid       = r_vld[NST];
    assign o_out.noise_value = r9_res;
    assign o_out.last_out    = r_last[NST];
endmodule

FILE: rtl/vn2d_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_pos
// Two-stage scaled position: offset + floor(coord * frequency).
// ----------------------------------------------------------------------------
module vn2d_pos (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [47:0]               i_coord,
    input  logic [47:0]               i_offset,
    input  logic [23:0]               i_freq,
    output logic [vn2d_pkg::POSW-1:0] o_pos
);
    import vn2d_pkg::*;

    logic [55:0]        r_plo;
    logic signed [40:0] r_phi;
    logic [47:0]        r_off;
    logic [POSW-1:0]    r_pos;
    logic [POSW-1:0]    n_pos;
    logic [63:0]        hi_ext;

    // Split the 48-bit coordinate so each product stays narrow
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= 56'(i_coord[31:0]) * 56'(i_freq);
            r_phi <= $signed(i_coord[47:32]) * $signed({1'b0, i_freq});
            r_off <= i_offset;
            r_pos <= n_pos;
        end
    end

    always_comb begin
        hi_ext = 64'($signed(r_phi)) << (32 - COORD_FRAC_BITS);
        n_pos  = POSW'(64'($signed(r_off)) + hi_ext + 64'(r_plo >> COORD_FRAC_BITS));
    end

    assign o_pos = r_pos;
endmodule

FILE: rtl/vn2d_wrom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_wrom
// Cosine weight table with registered read.
// ----------------------------------------------------------------------------
module vn2d_wrom (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [vn2d_pkg::AW-1:0] i_addr,
    output logic [vn2d_pkg::WW-1:0] o_data
);
    import vn2d_pkg::*;

    localparam t_wtab WTAB = build_wtab();

    logic [WW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= WTAB[i_addr];
        end
    end

    assign o_data = r_data;
endmodule

FILE: rtl/vn2d_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_hash
// Four-stage lattice hash; returns the corner value in Q1.30.
// ----------------------------------------------------------------------------
module vn2d_hash (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_idx,
    output logic signed [31:0] o_corner
);
    import vn2d_pkg::*;

    logic [31:0]        r_n0;
    logic [31:0]        r_n1;
    logic [31:0]        r_n2;
    logic [31:0]        r_m1;
    logic [31:0]        r_m2;
    logic signed [31:0] r_corner;
    logic [31:0]        m3;

    assign m3 = r_m2 * r_n2 + HASH_ADD2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n0     <= i_idx ^ (i_idx << 13);
            r_m1     <= r_n0 * r_n0;
            r_n1     <= r_n0;
            r_m2     <= r_m1 * HASH_MUL + HASH_ADD1;
            r_n2     <= r_n1;
            r_corner <= 32'sd1073741824 - $signed({1'b0, m3[30:0]});
        end
    end

    assign o_corner = r_corner;
endmodule

FILE: bench/vn2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_checker
// Watches both channels of the value noise sampler. It predicts the noise
// value of every sample item it sees accepted, then checks each accepted
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module vn2d_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    vn2d_in_if   i_in,
    vn2d_out_if  i_out,
    output int   o_errors,
    output int   o_pending
);
    import vn2d_pkg::*;

    typedef struct packed {
        logic [31:0] noise;
        logic        last;
    } t_noise_res;

    t_noise_res      noise_fifo[$];
    logic     [16:0] cos_weight [0:COS_TABLE_DEPTH];
    int              err_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = noise_fifo.size();

    // (1 - cos(pi*j/H)) / 2 in Q0.16 from an alternating series in Q30
    initial begin
        logic [63:0] th, th2, term, acc;
        int          n;
        bit          neg;
        for (int j = 0; j <= COS_TABLE_DEPTH; j++) begin
            th   = (64'd3373259426 * 64'(j)) / 64'(2 * COS_TABLE_DEPTH);
            th2  = (th * th) >> 30;
            term = th2 / 2;
            acc  = term;
            n    = 2;
            neg  = 1'b1;
            while (term != 0 && n < 40) begin
                term = ((term * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (neg) begin
                    acc = (acc >= term) ? acc - term : 64'd0;
                end else begin
                    acc = acc + term;
                end
                neg = !neg;
                n++;
            end
            if (acc > 64'd1073741824) acc = 64'd1073741824;
            cos_weight[j] = 17'((acc + 64'd16384) >> 15);
        end
    end

    // offset + floor(coord * freq / 2^16); only the low 48 bits matter
    function automatic logic [47:0] scaled_pos(logic [47:0] c, logic [47:0] off,
                                               logic [23:0] f);
        logic signed [79:0] prod;
        prod = $signed({{32{c[47]}}, c}) * $signed({56'd0, f});
        prod = prod >>> COORD_FRAC_BITS;
        return prod[47:0] + off;
    endfunction

    function automatic longint blend_weight(logic [47:0] pos);
        int k;
        k = int'(pos[15:0]) >> 5;
        if (k <= COS_TABLE_DEPTH) return longint'(cos_weight[k]);
        return 65536 - longint'(cos_weight[2 * COS_TABLE_DEPTH - k]);
    endfunction

    function automatic longint lattice_value(logic [31:0] idx);
        logic [31:0] m;
        idx = idx ^ (idx << 13);
        m   = idx * idx;
        m   = m * 32'd60493 + 32'd19990303;
        m   = m * idx + 32'd3521384707;
        return 64'd1073741824 - longint'({33'd0, m[30:0]});
    endfunction

    function automatic longint cos_lerp(longint p, longint q, longint t);
        return p + (((q - p) * t) >>> 16);
    endfunction

    function automatic logic [31:0] noise_sample(logic [47:0] cx, logic [47:0] cz,
                                                 logic [47:0] ox, logic [47:0] oz,
                                                 logic [23:0] f);
        logic [47:0] px, pz;
        logic [31:0] ix, r0, r1;
        longint      wx, wz, lo, hi;
        px = scaled_pos(cx, ox, f);
        pz = scaled_pos(cz, oz, f);
        ix = px[47:16];
        r0 = pz[47:16] * 32'(ROW_STEP);
        r1 = r0 + 32'(ROW_STEP);
        wx = blend_weight(px);
        wz = blend_weight(pz);
        lo = cos_lerp(lattice_value(ix + r0), lattice_value(ix + 1 + r0), wx);
        hi = cos_lerp(lattice_value(ix + r1), lattice_value(ix + 1 + r1), wx);
        return 32'(cos_lerp(lo, hi, wz));
    endfunction

    always @(posedge i_clk) begin
        t_noise_res want, got;
        if (!i_rst_n) begin
            err_cnt = 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                want.noise = i_in.slot_valid ? noise_sample(i_in.coord_x, i_in.coord_z,
                             i_in.offset_x, i_in.offset_z, i_in.frequency) : 32'd0;
                want.last  = i_in.last_octave;
                noise_fifo.push_back(want);
            end
            if (i_out.valid && i_out.ready) begin
                got.noise = i_out.noise_value;
                got.last  = i_out.last_out;
                if (noise_fifo.size() == 0) begin
                    $display("%0t: unexpected result noise=%h last=%b",
                             $time, got.noise, got.last);
                    err_cnt++;
                end else begin
                    want = noise_fifo.pop_front();
                    if (got.noise !== want.noise) begin
                        $display("%0t: noise_value expected %h actual %h",
                                 $time, want.noise, got.noise);
                        err_cnt++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_out expected %b actual %b",
                                 $time, want.last, got.last);
                        err_cnt++;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random octave samples into the value noise sampler
// under three idling patterns and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    localparam int STALL_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   gap_pct, stall_pct;
    int   quiet_cycles = 0;

    vn2d_in_if  in_ch ();
    vn2d_out_if out_ch ();

    value_noise_2d_sampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    vn2d_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic send_sample(logic [47:0] cx, logic [47:0] cz, logic [47:0] ox,
                               logic [47:0] oz, logic [23:0] f, logic sv, logic lst);
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.coord_x     <= cx;
        in_ch.coord_z     <= cz;
        in_ch.offset_x    <= ox;
        in_ch.offset_z    <= oz;
        in_ch.frequency   <= f;
        in_ch.slot_valid  <= sv;
        in_ch.last_octave <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic random_sample();
        logic [47:0] cx, cz, ox, oz;
        logic [23:0] f;
        cx = rand48();
        cz = rand48();
        ox = rand48();
        oz = rand48();
        f  = 24'($urandom());
        // mostly terrain-like coordinates near the origin
        if ($urandom_range(3) != 0) begin
            cx = 48'(signed'(32'($urandom_range(200000)) - 32'sd100000)) <<< 8;
            cz = 48'(signed'(32'($urandom_range(200000)) - 32'sd100000)) <<< 8;
            ox = {{16{ox[31]}}, ox[31:0]};
            oz = {{16{oz[31]}}, oz[31:0]};
            f  = 24'($urandom_range(24'h40000));
        end
        send_sample(cx, cz, ox, oz, f, $urandom_range(9) != 0, $urandom_range(3) == 0);
    endtask

    initial begin
        gap_pct           = 0;
        stall_pct         = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.coord_x     <= '0;
        in_ch.coord_z     <= '0;
        in_ch.offset_x    <= '0;
        in_ch.offset_z    <= '0;
        in_ch.frequency   <= '0;
        in_ch.slot_valid  <= 1'b0;
        in_ch.last_octave <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of every field, invalid slot, fractions on both table halves
        send_sample('0, '0, '0, '0, '0, 1'b1, 1'b0);
        send_sample(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                    48'h7FFF_FFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1);
        send_sample(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
                    48'h8000_0000_0000, 24'hFF_FFFF, 1'b1, 1'b0);
        send_sample(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, '0, '1, 24'hFF_FFFF, 1'b1, 1'b1);
        send_sample(48'h1_2345, 48'h2_8000, '0, '0, 24'h01_0000, 1'b0, 1'b1);
        send_sample(48'h1_2345, 48'h2_8000, '0, '0, 24'h01_0000, 1'b0, 1'b0);
        send_sample(48'h0_8000, 48'h0_8000, '0, '0, 24'h01_0000, 1'b1, 1'b0);
        send_sample(48'h0_7FFF, 48'h0_8001, '0, '0, 24'h01_0000, 1'b1, 1'b0);
        send_sample(48'h0_FFFF, 48'h0_0001, '0, '0, 24'h01_0000, 1'b1, 1'b0);
        send_sample(48'hFFFF_FFFF_0001, 48'hFFFF_FFFF_FFFF, '0, '0, 24'h01_0000, 1'b1, 1'b1);
        send_sample('0, '0, 48'h0000_1234_C000, 48'hFFFF_ABCD_3FFF, '0, 1'b1, 1'b0);
        send_sample('1, '1, '1, '1, 24'h00_0001, 1'b1, 1'b1);
        send_sample(48'h7FFF_FFFF_0000, 48'h8000_0000_FFFF, 48'h7FFF_0000_0000,
                    48'h8000_FFFF_FFFF, 24'h80_0000, 1'b1, 1'b0);

        gap_pct   = 17;
        stall_pct = 53;
        repeat (170) random_sample();
        gap_pct   = 53;
        stall_pct = 17;
        repeat (170) random_sample();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (170) random_sample();
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
